[sv/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
    } out_t;

    // shift commands broadcast to every cell
    typedef struct packed {
        logic push_back;
        logic shift_in;
        logic shift_out;
    } cmd_t;

endpackage

[sv/deq_cell.sv]
`timescale 1ns / 1ps

module deq_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5
) (
    input  logic                  clk,
    input  deq_pkg::cmd_t         cmd,
    input  logic [CW-1:0]         count,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] back_data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.push_back && (count == CW'(INDEX)))
        begin
            data_next = push_data;
        end
        else if (cmd.shift_in)
        begin
            data_next = left_data;
        end
        else if (cmd.shift_out)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // only the last occupied cell drives the back value
    assign back_data = (count == CW'(INDEX + 1)) ? data_reg : '0;

endmodule

[sv/double_ended_queue.sv]
`timescale 1ns / 1ps

// Bounded double-ended queue of CAPACITY elements held in a row of shift cells, front
// element always in the first cell. Each item is a push or pop at either end; each item
// gives one result with status (ok, underflow on an empty pop, overflow on a full push,
// the operation then being ignored), element count, empty flag, and front and back values
// after the operation (-1 when empty). The cells and the element count change on the
// accepting edge, and the result register loads from the cells when the pending item
// advances, which a stalled result can hold off. Items can be accepted every
// cycle while results are taken; a stalled result holds off new items one stage later.
// Pushed values keep their low DATA_WIDTH bits and come back sign-extended from it.

module double_ended_queue #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  deq_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output deq_pkg::out_t  out_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   pend_reg;
    deq_pkg::status_t       pend_status_reg;
    logic                   out_valid_reg;
    deq_pkg::out_t          out_reg;

    deq_pkg::cmd_t          cmd;
    deq_pkg::status_t       status;
    logic                   accept;
    logic                   advance;
    logic                   is_full;
    logic                   is_zero;
    logic [63:0]            value_wide;
    logic [DATA_WIDTH-1:0]  push_data;
    logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0]  cell_back [CAPACITY];
    logic [DATA_WIDTH-1:0]  back_or;
    logic signed [63:0]     front_ext;
    logic signed [63:0]     back_ext;

    assign advance  = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_reg || advance;
    assign accept   = in_valid && in_ready;

    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_zero  = (count_reg == '0);

    assign value_wide = {32'd0, in_data.value};
    assign push_data  = value_wide[DATA_WIDTH-1:0];

    always_comb
    begin
        cmd        = '0;
        status     = deq_pkg::ST_OK;
        count_next = count_reg;
        unique case (deq_pkg::op_t'(in_data.op))
            deq_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status = deq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    cmd.push_back = accept;
                    count_next    = count_reg + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status = deq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    cmd.shift_in = accept;
                    count_next   = count_reg + CW'(1);
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (is_zero)
                begin
                    status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (is_zero)
                begin
                    status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    cmd.shift_out = accept;
                    count_next    = count_reg - CW'(1);
                end
            end
            default:
            begin
                status = deq_pkg::ST_OK;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        deq_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .push_data  (push_data),
            .left_data  ((i == 0) ? push_data : cell_data[(i == 0) ? 0 : i - 1]),
            .right_data ((i == CAPACITY - 1) ? cell_data[i]
                                             : cell_data[(i == CAPACITY - 1) ? i : i + 1]),
            .data       (cell_data[i]),
            .back_data  (cell_back[i])
        );
    end

    always_comb
    begin
        back_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_or = back_or | cell_back[i];
        end
    end

    assign front_ext = 64'(signed'(cell_data[0]));
    assign back_ext  = 64'(signed'(back_or));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            pend_reg        <= 1'b0;
            pend_status_reg <= deq_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg       <= count_next;
                pend_status_reg <= status;
            end
            // cells already hold the state after the pending item
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                pend_reg <= 1'b1;
            end
            else if (advance)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.status   <= pend_status_reg;
            out_reg.count    <= deq_pkg::COUNT_W'(count_reg);
            out_reg.is_empty <= is_zero;
            if (is_zero)
            begin
                out_reg.front_value <= '1;
                out_reg.back_value  <= '1;
            end
            else
            begin
                out_reg.front_value <= front_ext[deq_pkg::VALUE_W-1:0];
                out_reg.back_value  <= back_ext[deq_pkg::VALUE_W-1:0];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.is_empty == (out_reg.count == '0)))
        else $error("empty flag disagrees with count");

    a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == deq_pkg::ST_UNDERFLOW)) |-> out_reg.is_empty)
        else $error("underflow reported on a non-empty queue");

    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == deq_pkg::ST_OVERFLOW))
            |-> (out_reg.count == deq_pkg::COUNT_W'(CAPACITY)))
        else $error("overflow reported on a queue that is not full");

    a_pend_update: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !advance) |=> ($stable(count_reg) || $past(accept)))
        else $error("count moved without an accepted item");

endmodule
